// ===== hw/rtl/migration_target_selector_assert.svh =====
`ifndef MIGRATION_TARGET_SELECTOR_ASSERT_SVH
`define MIGRATION_TARGET_SELECTOR_ASSERT_SVH

// Clocked assertion with reset disable and a fixed message.
`define MSEL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("msel assertion failed");

// Same, with a caller supplied message string.
`define MSEL_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

// ===== hw/rtl/msel_pkg.sv =====
package msel_pkg;

	localparam int LOAD_BITS   = 32;
	localparam int NODE_BITS   = 8;
	localparam int PID_BITS    = 22;
	localparam int STAB_BITS   = 10;
	localparam int FUNC_BITS   = 2;
	// stabilized load <= load * 11.23, fits in four extra bits
	localparam int STABLE_BITS = LOAD_BITS + 4;
	// floor(load / 100)
	localparam int QUOT_BITS   = LOAD_BITS - 6;
	localparam int REM_BITS    = 7;
	localparam int PROD_BITS   = REM_BITS + STAB_BITS;
	localparam int PART_BITS   = QUOT_BITS + STAB_BITS;

	// x / 100 = (x * RECIP_A) >> RECIP_A_SHIFT for 32-bit x
	localparam logic [30:0] RECIP_A       = 31'h51EB851F;
	localparam int          RECIP_A_SHIFT = 37;
	// y / 100 = (y * RECIP_B) >> RECIP_B_SHIFT for y < 2^17
	localparam logic [17:0] RECIP_B       = 18'd167773;
	localparam int          RECIP_B_SHIFT = 24;
	localparam logic [6:0]  PCT_DIV       = 7'd100;

	localparam logic [STAB_BITS-1:0] STAB_RESET = 10'd130;

	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = STAB_BITS;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STAB_PERCENT = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LOCAL_NODE   = 1'd1;

	localparam int IN_DATA_BITS  = 160;
	localparam int OUT_DATA_BITS = 40;

	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_PROC   = 2'd0,
		FUNC_NODE   = 2'd1,
		FUNC_DECIDE = 2'd2
	} func_t;

	typedef struct packed {
		logic proc;
		logic node;
		logic decide;
	} ctl_t;

	typedef struct packed {
		ctl_t                 ctl;
		logic [PID_BITS-1:0]  pid;
		logic [LOAD_BITS-1:0] tload;
		logic [NODE_BITS-1:0] node;
		logic [LOAD_BITS-1:0] cur;
	} item_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

// ===== hw/rtl/msel_stab.sv =====
module msel_stab (
	input  logic                                 clk,
	input  msel_pkg::stage_en_t                  en,
	input  logic [msel_pkg::STAB_BITS-1:0]       stab,
	input  logic [msel_pkg::LOAD_BITS-1:0]       pload_s1,
	input  logic [msel_pkg::LOAD_BITS-1:0]       nload_s1,
	output logic [msel_pkg::STABLE_BITS-1:0]     part_s5,
	output logic [msel_pkg::STAB_BITS-1:0]       frac_s5
);

	// load*pct/100 = q*pct + (r*pct)/100 with load = 100q + r
	logic [msel_pkg::LOAD_BITS+30:0]     recip_prod;
	logic [msel_pkg::QUOT_BITS-1:0]      quot_s2;
	logic [msel_pkg::LOAD_BITS-1:0]      pload_s2;
	logic [msel_pkg::LOAD_BITS-1:0]      nload_s2;
	logic [msel_pkg::LOAD_BITS-1:0]      rem_full;
	logic [msel_pkg::REM_BITS-1:0]       rem_s3;
	logic [msel_pkg::PART_BITS-1:0]      qscaled_s3;
	logic [msel_pkg::LOAD_BITS-1:0]      nload_s3;
	logic [msel_pkg::PROD_BITS-1:0]      rscaled_s4;
	logic [msel_pkg::STABLE_BITS-1:0]    part_s4;
	logic [msel_pkg::PROD_BITS+17:0]     frac_prod;

	assign recip_prod = pload_s1 * msel_pkg::RECIP_A;
	assign rem_full   = pload_s2 - msel_pkg::LOAD_BITS'(quot_s2 * msel_pkg::PCT_DIV);
	assign frac_prod  = rscaled_s4 * msel_pkg::RECIP_B;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			quot_s2  <= recip_prod[msel_pkg::RECIP_A_SHIFT +: msel_pkg::QUOT_BITS];
			pload_s2 <= pload_s1;
			nload_s2 <= nload_s1;
		end
		if (en.s3) begin
			rem_s3     <= rem_full[msel_pkg::REM_BITS-1:0];
			qscaled_s3 <= quot_s2 * stab;
			nload_s3   <= nload_s2;
		end
		if (en.s4) begin
			rscaled_s4 <= rem_s3 * stab;
			part_s4    <= msel_pkg::STABLE_BITS'(nload_s3)
				+ msel_pkg::STABLE_BITS'(qscaled_s3);
		end
		if (en.s5) begin
			frac_s5 <= frac_prod[msel_pkg::RECIP_B_SHIFT +: msel_pkg::STAB_BITS];
			part_s5 <= part_s4;
		end
	end

endmodule

// ===== hw/rtl/msel_track.sv =====
module msel_track (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  msel_pkg::item_t                      item_s5,
	input  logic [msel_pkg::STABLE_BITS-1:0]     part_s5,
	input  logic [msel_pkg::STAB_BITS-1:0]       frac_s5,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic [msel_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

	logic [msel_pkg::LOAD_BITS-1:0]      top_load_q;
	logic [msel_pkg::PID_BITS-1:0]       top_pid_q;
	logic                                top_valid_q;
	logic [msel_pkg::LOAD_BITS-1:0]      second_load_q;
	logic [msel_pkg::PID_BITS-1:0]       second_pid_q;
	logic                                second_valid_q;
	logic [msel_pkg::STABLE_BITS-1:0]    min_load_q;
	logic [msel_pkg::NODE_BITS-1:0]      min_node_q;
	logic                                min_valid_q;

	logic [msel_pkg::STABLE_BITS-1:0]    stable;
	logic                                task_found;
	logic [msel_pkg::PID_BITS-1:0]       chosen_pid;
	logic                                node_found;
	logic [msel_pkg::NODE_BITS-1:0]      dest_node;
	logic                                emit;

	assign stable      = part_s5 + msel_pkg::STABLE_BITS'(frac_s5);
	assign task_found  = top_valid_q | second_valid_q;
	assign chosen_pid  = second_valid_q ? second_pid_q
		: (top_valid_q ? top_pid_q : '0);
	assign node_found  = min_valid_q
		&& (min_load_q < msel_pkg::STABLE_BITS'(item_s5.cur));
	assign dest_node   = node_found ? min_node_q : '0;
	assign emit        = adv && item_s5.ctl.decide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_load_q     <= '0;
			top_pid_q      <= '0;
			top_valid_q    <= 1'b0;
			second_load_q  <= '0;
			second_pid_q   <= '0;
			second_valid_q <= 1'b0;
			min_load_q     <= '0;
			min_node_q     <= '0;
			min_valid_q    <= 1'b0;
			m_tvalid       <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (emit) begin
				top_load_q     <= '0;
				top_pid_q      <= '0;
				top_valid_q    <= 1'b0;
				second_load_q  <= '0;
				second_pid_q   <= '0;
				second_valid_q <= 1'b0;
				min_load_q     <= '0;
				min_node_q     <= '0;
				min_valid_q    <= 1'b0;
			end else if (adv && item_s5.ctl.proc) begin
				if (item_s5.tload > top_load_q) begin
					second_load_q  <= top_load_q;
					second_pid_q   <= top_pid_q;
					second_valid_q <= top_valid_q;
					top_load_q     <= item_s5.tload;
					top_pid_q      <= item_s5.pid;
					top_valid_q    <= 1'b1;
				end else if (item_s5.tload > second_load_q) begin
					second_load_q  <= item_s5.tload;
					second_pid_q   <= item_s5.pid;
					second_valid_q <= 1'b1;
				end
			end else if (adv && item_s5.ctl.node) begin
				if (!min_valid_q || stable < min_load_q) begin
					min_load_q  <= stable;
					min_node_q  <= item_s5.node;
					min_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= msel_pkg::OUT_DATA_BITS'({task_found & node_found, dest_node,
				node_found, chosen_pid, task_found});
		end
	end

endmodule

// ===== hw/rtl/migration_target_selector.sv =====
// Each input transfer is registered through stages s1 to s5, then its result in the output register.
// Throughput: one input transfer per cycle while results are taken.
// A decide record behind an untaken result holds the last stage; the stages
// behind it keep filling, and s_tready drops once all five hold items.
// Reset: asynchronous, clears pipeline valids, trackers and output valid,
// and loads stab_percent = 130, local_node = 0.
module migration_target_selector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// task id, task_load, task_usable, node_id, remote load, one_proc_load,
	// node_usable, local load
	input  logic [msel_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// func
	input  logic [msel_pkg::FUNC_BITS-1:0]       s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// task_found, chosen_pid, node_found, destination node, do_migrate, zero pad
	output logic [msel_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input  logic                                 cfg_we,
	input  logic [msel_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [msel_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

	logic [msel_pkg::STAB_BITS-1:0]      stab_q;
	logic [msel_pkg::NODE_BITS-1:0]      local_node_q;

	logic                                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                                rdy1, rdy2, rdy3, rdy4, rdy5;
	logic                                adv;
	msel_pkg::item_t                     item_in;
	msel_pkg::item_t                     item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [msel_pkg::LOAD_BITS-1:0]      pload_s1;
	logic [msel_pkg::LOAD_BITS-1:0]      nload_s1;
	msel_pkg::stage_en_t                 stage_en;
	logic [msel_pkg::STABLE_BITS-1:0]    part_s5;
	logic [msel_pkg::STAB_BITS-1:0]      frac_s5;

	assign adv      = vld_s5 && (!item_s5.ctl.decide || !m_tvalid || m_tready);
	assign rdy5     = !vld_s5 || adv;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign s_tready = rdy1;
	assign stage_en = '{s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

	assign item_in.ctl.proc   = (s_tuser == msel_pkg::FUNC_PROC) && s_tdata[54];
	assign item_in.ctl.node   = (s_tuser == msel_pkg::FUNC_NODE) && s_tdata[127]
		&& (s_tdata[62:55] != local_node_q);
	assign item_in.ctl.decide = (s_tuser == msel_pkg::FUNC_DECIDE);
	assign item_in.pid        = s_tdata[21:0];
	assign item_in.tload      = s_tdata[53:22];
	assign item_in.node       = s_tdata[62:55];
	assign item_in.cur        = s_tdata[159:128];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stab_q       <= msel_pkg::STAB_RESET;
			local_node_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				msel_pkg::CFG_STAB_PERCENT: begin
					stab_q <= cfg_wdata[msel_pkg::STAB_BITS-1:0];
				end
				msel_pkg::CFG_LOCAL_NODE: begin
					local_node_q <= cfg_wdata[msel_pkg::NODE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			item_s1  <= item_in;
			pload_s1 <= s_tdata[126:95];
			nload_s1 <= s_tdata[94:63];
		end
		if (rdy2) item_s2 <= item_s1;
		if (rdy3) item_s3 <= item_s2;
		if (rdy4) item_s4 <= item_s3;
		if (rdy5) item_s5 <= item_s4;
	end

	msel_stab u_stab (
		.clk      (clk),
		.en       (stage_en),
		.stab     (stab_q),
		.pload_s1 (pload_s1),
		.nload_s1 (nload_s1),
		.part_s5  (part_s5),
		.frac_s5  (frac_s5)
	);

	msel_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item_s5  (item_s5),
		.part_s5  (part_s5),
		.frac_s5  (frac_s5),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== hw/rtl/msel_chk.sv =====
`include "migration_target_selector_assert.svh"

module msel_chk (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [msel_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

	`MSEL_ASSERT_MSG(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	`MSEL_ASSERT_MSG(a_migrate, clk, arst_n, m_tvalid |-> (m_tdata[32] == (m_tdata[0] && m_tdata[23])), "do_migrate mismatch")
	`MSEL_ASSERT(a_no_node, clk, arst_n, m_tvalid && !m_tdata[23] |-> (m_tdata[31:24] == '0))
	`MSEL_ASSERT(a_no_task, clk, arst_n, m_tvalid && !m_tdata[0] |-> (m_tdata[22:1] == '0))
	`MSEL_ASSERT(a_in_stall, clk, arst_n, s_tvalid && !s_tready |-> m_tvalid && !m_tready)

endmodule

bind migration_target_selector msel_chk u_msel_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
